>>> rtl/core/gtp_pkg.sv
// ----------------------------------------------------------------------------
// gtp_pkg
// Shared types, constants and codes of the glyph tile painter.
// ----------------------------------------------------------------------------
package gtp_pkg;

  localparam int TILE_H       = 9;
  localparam int TILE_W       = 6;
  localparam int GLOW_RESET   = 52;
  localparam int STRIDE_RESET = 120;
  localparam int GLYPHS_DEF   = 64;
  localparam int ROWS_DEF     = 15;
  localparam int COLS_DEF     = 40;

  localparam int CMD_W    = 3;
  localparam int ROW_W    = 4;
  localparam int COL_W    = 6;
  localparam int GLYPH_W  = 6;
  localparam int LEVEL_W  = 6;
  localparam int COV_W    = 2;
  localparam int GLINE_W  = 4;
  localparam int WORD_W   = 16;
  localparam int ADDR_W   = 19;
  localparam int PIX_W    = 16;
  localparam int GROW_W   = 12;
  localparam int THR_W    = 6;
  localparam int STRIDE_W = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int ROW9_W   = 8;
  localparam int COL3_W   = 8;
  localparam int LINE_W   = 4;

  typedef enum logic [CMD_W-1:0] {
    OP_PAINT  = 3'd0,
    OP_PAL    = 3'd1,
    OP_PLAIN  = 3'd2,
    OP_GLOW   = 3'd3,
    OP_FORGET = 3'd4
  } gtp_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GLOW_THR = 1'b0,
    REG_STRIDE   = 1'b1
  } gtp_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_KEY_RD,
    ST_KEY_CHK,
    ST_PAL,
    ST_LINES,
    ST_TAIL
  } gtp_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [ROW_W-1:0]   cell_row;
    logic [COL_W-1:0]   cell_col;
    logic [GLYPH_W-1:0] glyph;
    logic [LEVEL_W-1:0] level;
    logic [COV_W-1:0]   coverage;
    logic [GLINE_W-1:0] glyph_line;
    logic [WORD_W-1:0]  table_word;
  } gtp_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] word_addr;
    logic [31:0]       pixels_01;
    logic [31:0]       pixels_23;
    logic [31:0]       pixels_45;
    logic              last_line;
  } gtp_out_t;

  typedef struct packed {
    logic               vld;
    logic [GLYPH_W-1:0] glyph;
    logic [LEVEL_W-1:0] level;
  } gtp_key_t;

  typedef struct packed {
    logic load_in;
    logic pal_wr;
    logic plain_wr;
    logic glow_wr;
    logic clr_wr;
    logic key_rd;
    logic key_wr;
    logic pal_rd;
    logic line_issue;
  } gtp_cmd_t;

  typedef struct packed {
    logic paint_ok;
    logic gload_ok;
    logic key_hit;
    logic clr_last;
    logic pal_last;
    logic line_last;
    logic adv;
    logic b_vld;
  } gtp_sts_t;

endpackage

>>> rtl/core/gtp_ctrl.sv
// ----------------------------------------------------------------------------
// gtp_ctrl
// Sequencer of the glyph tile painter: key clear sweep, command decode,
// key check, palette fetch and line issue.
// ----------------------------------------------------------------------------
module gtp_ctrl
  import gtp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] in_cmd_i,
  input  gtp_sts_t         sts_i,
  output gtp_cmd_t         cmd_o,
  output logic             in_stall_o
);

  gtp_state_e state_q, state_d;
  gtp_op_e    op;

  assign op = gtp_op_e'(in_cmd_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op)
            OP_PAINT: begin
              if (sts_i.paint_ok) state_d = ST_KEY_RD;
            end
            OP_FORGET: state_d = ST_CLEAR;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_KEY_RD:  state_d = ST_KEY_CHK;
      ST_KEY_CHK: begin
        state_d = sts_i.key_hit ? ST_IDLE : ST_PAL;
      end
      ST_PAL: begin
        if (sts_i.pal_last) state_d = ST_LINES;
      end
      ST_LINES: begin
        if (sts_i.adv && sts_i.line_last) state_d = ST_TAIL;
      end
      ST_TAIL: begin
        if (!sts_i.b_vld) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          case (op)
            OP_PAL:   cmd_o.pal_wr   = 1'b1;
            OP_PLAIN: cmd_o.plain_wr = sts_i.gload_ok;
            OP_GLOW:  cmd_o.glow_wr  = sts_i.gload_ok;
            default:  cmd_o.pal_wr   = 1'b0;
          endcase
        end
      end
      ST_KEY_RD:  cmd_o.key_rd = 1'b1;
      ST_KEY_CHK: cmd_o.key_wr = !sts_i.key_hit;
      ST_PAL:     cmd_o.pal_rd = 1'b1;
      ST_LINES:   cmd_o.line_issue = 1'b1;
      ST_TAIL:    cmd_o.line_issue = 1'b0;
      default:    cmd_o = '0;
    endcase
  end

endmodule

>>> rtl/core/gtp_datapath.sv
// ----------------------------------------------------------------------------
// gtp_datapath
// Stores (painted keys, palette, glyph rows), configuration registers,
// address and line counters, line read stage and output register.
// ----------------------------------------------------------------------------
module gtp_datapath
  import gtp_pkg::*;
#(
  parameter int GLYPHS = GLYPHS_DEF,
  parameter int ROWS   = ROWS_DEF,
  parameter int COLS   = COLS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gtp_in_t               in_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  gtp_cmd_t              cmd_i,
  output gtp_sts_t              sts_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output gtp_out_t              out_data_o
);

  localparam int NCELL  = ROWS * COLS;
  localparam int CELL_W = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int NGROW  = GLYPHS * TILE_H;
  localparam int GIDX_W = $clog2(NGROW);

  gtp_key_t            key_mem [NCELL];
  logic [PIX_W-1:0]    pal_mem [256];
  logic [GROW_W-1:0]   plain_mem [NGROW];
  logic [GROW_W-1:0]   glow_mem [NGROW];

  logic [THR_W-1:0]    glow_thr_q;
  logic [STRIDE_W-1:0] stride_q;

  logic [CELL_W-1:0]   clr_cnt_q;
  logic [1:0]          pal_cnt_q;
  logic [LINE_W-1:0]   line_q;
  logic                b_vld_q;
  logic                out_vld_q;

  logic [CELL_W-1:0]   cell_q;
  logic [GLYPH_W-1:0]  glyph_q;
  logic [LEVEL_W-1:0]  level_q;
  logic [ROW9_W-1:0]   row9_q;
  logic [COL3_W-1:0]   col3_q;
  logic [GIDX_W-1:0]   gbase_q;
  logic                use_glow_q;
  gtp_key_t            key_rd_q;
  logic [PIX_W-1:0]    pal_q [4];
  logic [ADDR_W-1:0]   addr_q;
  logic [ADDR_W-1:0]   b_addr_q;
  logic                b_last_q;
  logic [GROW_W-1:0]   plain_rd_q;
  logic [GROW_W-1:0]   glow_rd_q;
  gtp_out_t            out_q;

  logic                adv;
  logic                issue;
  logic [GIDX_W-1:0]   gw_idx;
  logic [GIDX_W-1:0]   gr_idx;
  logic [CELL_W-1:0]   cell_d;
  gtp_key_t            new_key;
  logic [GROW_W-1:0]   row_bits;
  logic [PIX_W-1:0]    pix [TILE_W];
  gtp_out_t            fmt;

  assign adv    = !out_vld_q || !out_stall_i;
  assign issue  = cmd_i.line_issue && adv;
  assign gw_idx = GIDX_W'(int'(in_data_i.glyph) * TILE_H + int'(in_data_i.glyph_line));
  assign gr_idx = gbase_q + GIDX_W'(line_q);
  assign cell_d = CELL_W'(int'(in_data_i.cell_row) * COLS + int'(in_data_i.cell_col));

  assign new_key.vld   = 1'b1;
  assign new_key.glyph = glyph_q;
  assign new_key.level = level_q;

  assign sts_o.paint_ok  = (int'(in_data_i.cell_row) < ROWS) &&
                           (int'(in_data_i.cell_col) < COLS) &&
                           (int'(in_data_i.glyph) < GLYPHS);
  assign sts_o.gload_ok  = (int'(in_data_i.glyph) < GLYPHS) &&
                           (int'(in_data_i.glyph_line) < TILE_H);
  assign sts_o.key_hit   = (key_rd_q == new_key);
  assign sts_o.clr_last  = (clr_cnt_q == CELL_W'(NCELL - 1));
  assign sts_o.pal_last  = (pal_cnt_q == 2'd3);
  assign sts_o.line_last = (line_q == LINE_W'(TILE_H - 1));
  assign sts_o.adv       = adv;
  assign sts_o.b_vld     = b_vld_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glow_thr_q <= THR_W'(GLOW_RESET);
      stride_q   <= STRIDE_W'(STRIDE_RESET);
    end else if (cfg_we_i) begin
      case (gtp_reg_e'(cfg_index_i))
        REG_GLOW_THR: glow_thr_q <= cfg_data_i[THR_W-1:0];
        REG_STRIDE:   stride_q   <= cfg_data_i[STRIDE_W-1:0];
        default:      stride_q   <= stride_q;
      endcase
    end
  end

  // control counters and valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      pal_cnt_q <= '0;
      line_q    <= '0;
      b_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= sts_o.clr_last ? '0 : clr_cnt_q + CELL_W'(1);
      end
      if (cmd_i.pal_rd) begin
        pal_cnt_q <= pal_cnt_q + 2'd1;
      end
      if (issue) begin
        line_q <= sts_o.line_last ? '0 : line_q + LINE_W'(1);
      end
      if (adv) begin
        b_vld_q   <= cmd_i.line_issue;
        out_vld_q <= b_vld_q;
      end
    end
  end

  // command capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cell_q     <= cell_d;
      glyph_q    <= in_data_i.glyph;
      level_q    <= in_data_i.level;
      row9_q     <= ROW9_W'(int'(in_data_i.cell_row) * TILE_H);
      col3_q     <= COL3_W'(int'(in_data_i.cell_col) * 3);
      gbase_q    <= GIDX_W'(int'(in_data_i.glyph) * TILE_H);
      use_glow_q <= (in_data_i.level >= glow_thr_q);
    end
  end

  // painted keys
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      key_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.key_wr) begin
      key_mem[cell_q] <= new_key;
    end
    if (cmd_i.key_rd) begin
      key_rd_q <= key_mem[cell_q];
    end
  end

  // palette
  always_ff @(posedge clk_i) begin
    if (cmd_i.pal_wr) begin
      pal_mem[{in_data_i.level, in_data_i.coverage}] <= in_data_i.table_word;
    end
    if (cmd_i.pal_rd) begin
      pal_q[pal_cnt_q] <= pal_mem[{level_q, pal_cnt_q}];
    end
  end

  // glyph stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.plain_wr) begin
      plain_mem[gw_idx] <= in_data_i.table_word[GROW_W-1:0];
    end
    if (cmd_i.glow_wr) begin
      glow_mem[gw_idx] <= in_data_i.table_word[GROW_W-1:0];
    end
    if (issue) begin
      plain_rd_q <= plain_mem[gr_idx];
      glow_rd_q  <= glow_mem[gr_idx];
    end
  end

  // line addresses
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_rd) begin
      addr_q <= ADDR_W'(row9_q) * ADDR_W'(stride_q) + ADDR_W'(col3_q);
    end else if (issue) begin
      addr_q <= addr_q + ADDR_W'(stride_q);
    end
    if (issue) begin
      b_addr_q <= addr_q;
      b_last_q <= sts_o.line_last;
    end
  end

  // pixel lookup
  always_comb begin
    row_bits = use_glow_q ? glow_rd_q : plain_rd_q;
    for (int p = 0; p < TILE_W; p++) begin
      pix[p] = pal_q[row_bits[2*p +: 2]];
    end
    fmt.word_addr = b_addr_q;
    fmt.pixels_01 = {pix[1], pix[0]};
    fmt.pixels_23 = {pix[3], pix[2]};
    fmt.pixels_45 = {pix[5], pix[4]};
    fmt.last_line = b_last_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv && b_vld_q) begin
      out_q <= fmt;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/core/glyph_tile_painter.sv
// ----------------------------------------------------------------------------
// glyph_tile_painter
// Character-cell tile renderer with a 2-bit coverage RGB565 palette.
//
// Input channel (in_valid_i / in_stall_o) takes one command per transfer:
// paint a cell, load a palette entry, load a plain or glow glyph row, or
// forget all painted keys. Loads and forget give no output. A paint whose
// glyph and level equal what that cell last painted gives no output either;
// any other paint within range gives nine line transfers on the output channel
// (out_valid_o / out_stall_i), one framebuffer line each, last_line set on
// the ninth. Configuration writes (cfg_valid_i / cfg_ready_o) are always
// taken and must only be issued while the block is idle.
// A repeated paint goes through key read and key check only; a changed paint
// then writes its key, does four palette reads through the single palette
// read port and nine glyph row reads, and waits for the line read stage to
// drain. Loads are taken from the idle state. A stall on the output holds
// the line read stage and output register, and the next command is taken
// once the painted lines have left the read stage. After reset, and after
// forget, the key store is cleared one cell per cycle, all ROWS*COLS cells
// (600 at default size), with in_stall_o high.
// ----------------------------------------------------------------------------
module glyph_tile_painter
  import gtp_pkg::*;
#(
  parameter int GLYPHS = GLYPHS_DEF,
  parameter int ROWS   = ROWS_DEF,
  parameter int COLS   = COLS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  gtp_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output gtp_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  gtp_cmd_t cmd;
  gtp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  gtp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  gtp_datapath #(
    .GLYPHS (GLYPHS),
    .ROWS   (ROWS),
    .COLS   (COLS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // idle only with the line read stage empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !sts.b_vld)
    else $error("input taken while a line is still in the read stage");

  // a key is written only right after its cell was read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.key_wr |-> $past(cmd.key_rd))
    else $error("key written without a preceding key read");

  // no line issue once the ninth line has gone out of the issue stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.line_issue && sts.adv && sts.line_last |=> !cmd.line_issue)
    else $error("more than nine lines issued for one paint");

  // the clear sweep never overlaps an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> in_stall_o)
    else $error("input transfer during key clear sweep");

endmodule
